[sv/tcs_pkg.sv]
// Shared widths, register codes and controller/datapath interface types.
`default_nettype none

package tcs_pkg;

    // Fixed field widths of the streaming items.
    localparam int BIN_W        = 11;
    localparam int SAMPLE_IN_W  = 24;
    localparam int ABS_W        = 48;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 64;

    // Configuration registers.
    localparam int GAIN_W       = 32;
    localparam int SHIFT_W      = 6;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SHIFT = 1'd1;
    localparam logic [GAIN_W-1:0]    GAIN_RESET    = 32'd65536;
    localparam logic [SHIFT_W-1:0]   SHIFT_RESET   = 6'd16;

    // Fixed part of the final right shift: 16 for the Q16.16 gain, 1 for the
    // half taken by the trapezoid rule.
    localparam int SHIFT_BIAS   = 17;

    // Command kinds carried in s_tuser.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_BIN    = 1'b1;

    // Default configuration of the block.
    localparam int INTERVALS_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COS_BITS_DEF    = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_we;
        logic bin_load;
        logic reduce_step;
        logic sweep_start;
        logic sweep_step;
        logic scale0;
        logic scale1;
        logic mul_step;
        logic shift;
        logic out_load;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kred_ge;
        logic sweep_last;
        logic pipe_busy;
        logic mul_last;
        logic out_full;
    } sts_t;

endpackage

`default_nettype wire

[sv/tcs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1025
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/tcs_cos_rom.sv]
// Cosine table over one full turn, built at elaboration, with registered read.
`default_nettype none

module tcs_cos_rom #(
    parameter int unsigned INTERVALS = 1024,
    parameter int unsigned COS_BITS  = 16
) (
    input  wire logic                           clk,
    input  wire logic [$clog2(INTERVALS)-1:0]   addr,
    output logic signed [COS_BITS-1:0]          data_reg
);

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave cosine by a Horner Taylor series in Q30, each step
    // truncated and clamped at zero, then rounded to COS_BITS-1 fraction bits.
    function automatic logic signed [COS_BITS-1:0] cos_entry(input int unsigned p);
        longint unsigned q4;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned h;
        longint unsigned sub;
        longint unsigned v;
        longint unsigned maxv;
        longint          res;
        int unsigned     sh;
        q4   = 64'(p) * 64'd4;
        quad = q4 / INTERVALS;
        r    = q4 % INTERVALS;
        if (quad[0])
        begin
            r = 64'(INTERVALS) - r;
        end
        t  = (r * HALF_PI_Q30) / INTERVALS;
        t2 = (t * t) >> 30;
        h  = Q30_ONE;
        sub = ((t2 * h) >> 30) / 64'd182;
        h   = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((t2 * h) >> 30) / 64'd132;
        h   = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((t2 * h) >> 30) / 64'd90;
        h   = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((t2 * h) >> 30) / 64'd56;
        h   = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((t2 * h) >> 30) / 64'd30;
        h   = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((t2 * h) >> 30) / 64'd12;
        h   = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((t2 * h) >> 30) / 64'd2;
        h   = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sh   = 30 - (COS_BITS - 1);
        maxv = (64'd1 << (COS_BITS - 1)) - 64'd1;
        v    = (h + (64'd1 << (sh - 1))) >> sh;
        if (v > maxv)
        begin
            v = maxv;
        end
        if (quad == 64'd1 || quad == 64'd2)
        begin
            res = -longint'(v);
        end
        else
        begin
            res = longint'(v);
        end
        return COS_BITS'(res);
    endfunction

    logic signed [COS_BITS-1:0] rom_tab [INTERVALS];

    for (genvar g = 0; g < INTERVALS; g++)
    begin : g_rom
        localparam logic signed [COS_BITS-1:0] CosVal = cos_entry(g);
        assign rom_tab[g] = CosVal;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_tab[addr];
    end

endmodule

`default_nettype wire

[sv/tcs_datapath.sv]
// Datapath: sample store, cosine multiply-accumulate, scaling and output register.
`default_nettype none

module tcs_datapath
    import tcs_pkg::*;
#(
    parameter int unsigned INTERVALS   = INTERVALS_DEF,
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int unsigned COS_BITS    = COS_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ctl_t                            ctl,
    output sts_t                                 sts,
    input  wire logic        [BIN_W-1:0]         sample_index,
    input  wire logic signed [SAMPLE_IN_W-1:0]   sample_value,
    input  wire logic        [BIN_W-1:0]         bin_index,
    input  wire logic                            cfg_we,
    input  wire logic        [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic        [CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                            m_tready,
    output logic                                 out_valid,
    output logic             [BIN_W-1:0]         bin_out,
    output logic signed      [ABS_W-1:0]         absorbance,
    output logic                                 saturated
);

    localparam int AW     = $clog2(INTERVALS + 1);
    localparam int PH_W   = $clog2(INTERVALS);
    localparam int PS_W   = PH_W + 1;
    localparam int RW     = (BIN_W >= PH_W) ? BIN_W : PH_W;
    localparam int PROD_W = SAMPLE_BITS + COS_BITS;
    localparam int ACC_W  = PROD_W + 2 + $clog2(INTERVALS + 1);
    localparam int NA     = (ACC_W + 31) / 32;
    localparam int A_W    = NA * 32;
    localparam int IW     = (NA > 1) ? $clog2(NA) : 1;
    localparam int PSH_W  = IW + 1;
    localparam int KK_W   = 2 * BIN_W;
    localparam int M_W    = KK_W + GAIN_W;
    localparam int P_W    = A_W + 64;
    localparam int SH_W   = 7;

    // Configuration registers.
    logic [GAIN_W-1:0]  gain_reg;
    logic [SHIFT_W-1:0] shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            shift_reg <= SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN:      gain_reg  <= cfg_wdata;
                REG_OUT_SHIFT: shift_reg <= cfg_wdata[SHIFT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Sample store.
    logic                          ram_we;
    logic        [AW-1:0]          n_reg;
    logic signed [SAMPLE_BITS-1:0] ram_rdata;

    assign ram_we = ctl.load_we && (32'(sample_index) <= INTERVALS);

    tcs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (INTERVALS + 1)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(sample_index)),
        .wdata (SAMPLE_BITS'(sample_value)),
        .raddr (n_reg),
        .rdata (ram_rdata)
    );

    // Bin register and reduction of k below INTERVALS.
    logic [BIN_W-1:0] bin_reg;
    logic [RW-1:0]    kred_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.bin_load)
        begin
            bin_reg  <= bin_index;
            kred_reg <= RW'(bin_index);
        end
        else if (ctl.reduce_step)
        begin
            kred_reg <= kred_reg - RW'(INTERVALS);
        end
    end

    // Sweep over the sample grid with a wrapping phase accumulator.
    logic [PH_W-1:0] phase_reg;
    logic [PH_W-1:0] phase_next;
    logic [PS_W-1:0] ph_sum;
    logic            sweep_last;

    assign sweep_last = (32'(n_reg) == INTERVALS);
    assign ph_sum     = PS_W'(phase_reg) + PS_W'(kred_reg[PH_W-1:0]);

    always_comb
    begin
        if (32'(ph_sum) >= INTERVALS)
        begin
            phase_next = PH_W'(ph_sum - PS_W'(INTERVALS));
        end
        else
        begin
            phase_next = PH_W'(ph_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sweep_start)
        begin
            n_reg     <= '0;
            phase_reg <= '0;
        end
        else if (ctl.sweep_step)
        begin
            n_reg     <= n_reg + AW'(1);
            phase_reg <= phase_next;
        end
    end

    logic signed [COS_BITS-1:0] cos_data;

    tcs_cos_rom #(
        .INTERVALS (INTERVALS),
        .COS_BITS  (COS_BITS)
    ) u_rom (
        .clk      (clk),
        .addr     (phase_reg),
        .data_reg (cos_data)
    );

    // Multiply-accumulate pipeline: read, multiply, accumulate.
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     end1_reg;
    logic                     end2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.sweep_step;
            v2_reg <= v1_reg;
        end
    end

    // End points of the grid carry weight one, interior points weight two.
    always_comb
    begin
        if (end2_reg)
        begin
            term = ACC_W'(prod_reg);
        end
        else
        begin
            term = ACC_W'(prod_reg) <<< 1;
        end
    end

    always_ff @(posedge clk)
    begin
        end1_reg <= (n_reg == '0) || sweep_last;
        end2_reg <= end1_reg;
        prod_reg <= ram_rdata * cos_data;
        if (ctl.sweep_start)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + term;
        end
    end

    // Scaling: magnitude of the sum times k*k*gain, in 32-bit partial products.
    logic              neg_reg;
    logic [ACC_W-1:0]  mag_reg;
    logic [KK_W-1:0]   kk_reg;
    logic [M_W-1:0]    m_reg;
    logic [IW-1:0]     i_reg;
    logic              j_reg;
    logic [63:0]       pp_reg;
    logic [PSH_W-1:0]  pp_sh_reg;
    logic              ppv_reg;
    logic [P_W-1:0]    p_reg;
    logic [P_W-1:0]    s_reg;
    logic [A_W-1:0]    mag_pad;
    logic [63:0]       m_pad;
    logic [31:0]       a_sel;
    logic [31:0]       b_sel;
    logic              mul_last;

    assign mag_pad  = A_W'(mag_reg);
    assign m_pad    = 64'(m_reg);
    assign a_sel    = 32'(mag_pad >> {i_reg, 5'd0});
    assign b_sel    = j_reg ? m_pad[63:32] : m_pad[31:0];
    assign mul_last = (i_reg == IW'(NA - 1)) && j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppv_reg <= 1'b0;
        end
        else
        begin
            ppv_reg <= ctl.mul_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.scale0)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_reg[ACC_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
            kk_reg  <= KK_W'(bin_reg) * KK_W'(bin_reg);
        end
        if (ctl.scale1)
        begin
            m_reg <= M_W'(kk_reg) * M_W'(gain_reg);
            i_reg <= '0;
            j_reg <= 1'b0;
            p_reg <= '0;
        end
        else
        begin
            if (ctl.mul_step)
            begin
                pp_reg    <= 64'(a_sel) * 64'(b_sel);
                pp_sh_reg <= PSH_W'(i_reg) + PSH_W'(j_reg);
                j_reg     <= ~j_reg;
                if (j_reg)
                begin
                    i_reg <= i_reg + IW'(1);
                end
            end
            if (ppv_reg)
            begin
                p_reg <= p_reg + (P_W'(pp_reg) << {pp_sh_reg, 5'd0});
            end
        end
        if (ctl.shift)
        begin
            s_reg <= p_reg >> (SH_W'(shift_reg) + SH_W'(SHIFT_BIAS));
        end
    end

    // Saturation to 48 bits and the output register.
    logic                    sat_next;
    logic [ABS_W-1:0]        mag48;
    logic signed [ABS_W-1:0] abs_next;
    logic                    out_valid_reg;
    logic [BIN_W-1:0]        bin_out_reg;
    logic signed [ABS_W-1:0] abs_reg;
    logic                    sat_reg;

    always_comb
    begin
        sat_next = (|s_reg[P_W-1:ABS_W])
                || (s_reg[ABS_W-1] && (!neg_reg || (|s_reg[ABS_W-2:0])));
        if (sat_next)
        begin
            mag48 = neg_reg ? {1'b1, {(ABS_W-1){1'b0}}} : {1'b0, {(ABS_W-1){1'b1}}};
        end
        else
        begin
            mag48 = s_reg[ABS_W-1:0];
        end
        abs_next = neg_reg ? -$signed(mag48) : $signed(mag48);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            bin_out_reg <= bin_reg;
            abs_reg     <= abs_next;
            sat_reg     <= sat_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bin_out    = bin_out_reg;
    assign absorbance = abs_reg;
    assign saturated  = sat_reg;

    assign sts.kred_ge    = (32'(kred_reg) >= INTERVALS);
    assign sts.sweep_last = sweep_last;
    assign sts.pipe_busy  = v1_reg || v2_reg;
    assign sts.mul_last   = mul_last;
    assign sts.out_full   = out_valid_reg && !m_tready;

endmodule

`default_nettype wire

[sv/tcs_ctrl.sv]
// Controller state machine that sequences loads and bin computations.
`default_nettype none

module tcs_ctrl
    import tcs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    input  wire logic cmd,
    output logic      s_tready,
    input  wire sts_t sts,
    output ctl_t      ctl
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_REDUCE = 10'b00_0000_0010,
        ST_SWEEP  = 10'b00_0000_0100,
        ST_DRAIN  = 10'b00_0000_1000,
        ST_SCALE0 = 10'b00_0001_0000,
        ST_SCALE1 = 10'b00_0010_0000,
        ST_MULT   = 10'b00_0100_0000,
        ST_MFIN   = 10'b00_1000_0000,
        ST_SHIFT  = 10'b01_0000_0000,
        ST_OUT    = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (cmd == CMD_BIN)
                    begin
                        ctl.bin_load = 1'b1;
                        state_next   = ST_REDUCE;
                    end
                    else
                    begin
                        ctl.load_we = 1'b1;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (sts.kred_ge)
                begin
                    ctl.reduce_step = 1'b1;
                end
                else
                begin
                    ctl.sweep_start = 1'b1;
                    state_next      = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                ctl.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_SCALE0;
                end
            end
            ST_SCALE0:
            begin
                ctl.scale0 = 1'b1;
                state_next = ST_SCALE1;
            end
            ST_SCALE1:
            begin
                ctl.scale1 = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                ctl.mul_step = 1'b1;
                if (sts.mul_last)
                begin
                    state_next = ST_MFIN;
                end
            end
            ST_MFIN:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                ctl.shift  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!sts.out_full)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/trapezoid_cosine_spectrum.sv]
// Top level of the trapezoidal cosine transform spectrum unit.
//
// Usage: items arrive on the s_t* stream. s_tuser selects the command: a load
// transaction writes one correlation sample (sample_index, sample_value) into
// the sample store, or is dropped if sample_index exceeds INTERVALS; a bin
// transaction computes one frequency bin k and produces exactly one result
// transaction on the m_t* stream. Loads produce nothing. The gain and
// out_shift registers are to be written through cfg_we, cfg_index and
// cfg_wdata while the block is idle; the block itself does not enforce this.
// A load transaction does not leave the idle state, so s_tready stays high.
// A bin transaction sweeps all INTERVALS + 1 stored samples through the
// single multiply-accumulate, then runs the scaling steps; bins at or above
// INTERVALS first take one reduction step per wrap. While a bin is being
// computed s_tready stays low. The result sits in an output register, so a
// new transaction is taken while m_tvalid waits; if the receiver holds
// m_tready low, a following bin finishes its sweep and scaling and then
// waits until the output register frees up. Reset restores gain and
// out_shift and empties the output register; the sample store is not
// cleared, and every sample must be loaded before a bin is computed.
`default_nettype none

module trapezoid_cosine_spectrum
    import tcs_pkg::*;
#(
    parameter int unsigned INTERVALS   = INTERVALS_DEF,
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int unsigned COS_BITS    = COS_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // sample_index [10:0], sample_value [34:11], bin_index [45:35], zero fill
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // cmd [0]
    input  wire logic [0:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // bin_out [10:0], absorbance [58:11], zero fill
    output logic [M_TDATA_W-1:0]       m_tdata,
    // saturated [0]
    output logic [0:0]                 m_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Unpacked input fields.
    logic        [BIN_W-1:0]       sample_index;
    logic signed [SAMPLE_IN_W-1:0] sample_value;
    logic        [BIN_W-1:0]       bin_index;

    assign sample_index = s_tdata[BIN_W-1:0];
    assign sample_value = $signed(s_tdata[BIN_W+SAMPLE_IN_W-1:BIN_W]);
    assign bin_index    = s_tdata[2*BIN_W+SAMPLE_IN_W-1:BIN_W+SAMPLE_IN_W];

    ctl_t ctl;
    sts_t sts;

    logic        [BIN_W-1:0] bin_out;
    logic signed [ABS_W-1:0] absorbance;
    logic                    saturated;

    tcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .cmd      (s_tuser[0]),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    tcs_datapath #(
        .INTERVALS   (INTERVALS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COS_BITS    (COS_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .bin_index    (bin_index),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .m_tready     (m_tready),
        .out_valid    (m_tvalid),
        .bin_out      (bin_out),
        .absorbance   (absorbance),
        .saturated    (saturated)
    );

    // Pack the result fields, lowest field in the lowest bits.
    assign m_tdata = {{(M_TDATA_W-BIN_W-ABS_W){1'b0}}, absorbance, bin_out};
    assign m_tuser = saturated;

    // The output register is only loaded when it is empty or being drained.
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> !sts.out_full)
        else $error("result loaded over a pending result");

    // A loaded result is presented on the next cycle.
    a_out_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> m_tvalid)
        else $error("loaded result not presented");

    // Scaling starts only after the multiply-accumulate pipeline has drained.
    a_scale_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scale0 |-> !sts.pipe_busy)
        else $error("scaling started with terms still in flight");

    // No new transaction is taken while terms are still being accumulated.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !sts.pipe_busy)
        else $error("transaction accepted during accumulation");

endmodule

`default_nettype wire

[test/tb_trapezoid_cosine_spectrum.sv]
// Self-checking testbench for trapezoid_cosine_spectrum: random stream traffic with a built-in spectrum predictor.
module tb_trapezoid_cosine_spectrum;
    import tcs_pkg::*;

    // Grid and number formats of the default build of the block.
    localparam int GRID          = INTERVALS_DEF;
    localparam int COS_FRAC      = COS_BITS_DEF - 1;
    localparam int COS_SHIFT     = 30 - COS_FRAC;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned COS_MAX     = (64'd1 << COS_FRAC) - 1;
    localparam logic [127:0] ABS_LIM = 128'd1 << (ABS_W - 1);
    localparam logic [BIN_W-1:0]       BIN_MAX    = '1;
    localparam logic [SAMPLE_IN_W-1:0] SAMPLE_MIN = 24'h800000;
    localparam logic [SAMPLE_IN_W-1:0] SAMPLE_MAX = 24'h7FFFFF;

    // After the last expected result the block may still be busy with a load,
    // so every pause allows a full bin.
    localparam int SETTLE_CYCLES = GRID + 64;
    // The receiver holds off long enough for two bins to pile up inside the
    // block, which forces s_tready low while the sender keeps offering.
    localparam int HOLD_CYCLES   = 4 * (GRID + 16);
    // No transaction may be missing for this many cycles in a correct run.
    localparam int IDLE_LIMIT    = 20 * (GRID + 16);
    localparam int MAX_REPORTS   = 10;

    // One input transaction, field by field.
    typedef struct packed {
        logic                   cmd;
        logic [BIN_W-1:0]       sample_index;
        logic [SAMPLE_IN_W-1:0] sample_value;
        logic [BIN_W-1:0]       bin_index;
    } spec_item_t;

    // One result transaction, field by field.
    typedef struct packed {
        logic [BIN_W-1:0] bin_out;
        logic [ABS_W-1:0] absorbance;
        logic             saturated;
    } bin_result_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    trapezoid_cosine_spectrum dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: our own copy of the sample store, the cosine ROM and
    // the two configuration registers.
    logic signed [SAMPLE_IN_W-1:0] corr_store [0:GRID];
    int                            cos_table  [0:GRID-1];
    logic [GAIN_W-1:0]             gain_now  = GAIN_RESET;
    logic [SHIFT_W-1:0]            shift_now = SHIFT_RESET;

    spec_item_t  cmd_queue[$];   // transactions waiting to be offered
    bin_result_t bins_due[$];    // predicted bins, oldest first
    spec_item_t  cur_item;
    bin_result_t seen_bin;
    bin_result_t want_bin;

    int unsigned tx_gap      = 0;
    int unsigned tx_calm     = 0;
    int unsigned rx_gap      = 0;
    int unsigned rx_calm     = 0;
    int unsigned hold_left   = 0;
    bit          hold_taken  = 1'b0;
    logic        hold_req    = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches  = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 16);
        return $urandom_range(40, 200);
    endfunction

    // Expected result of a bin: k*k*gain times the trapezoid sum, scaled down
    // and clipped to 48 bits. The sum is kept doubled so that the half weight
    // of the two end samples stays exact; the extra shift takes the half.
    function automatic bin_result_t predict_bin(input logic [BIN_W-1:0] k);
        logic signed [127:0] twice_sum;
        longint              term;
        logic [127:0]        mag;
        logic [127:0]        scaled;
        logic [63:0]         k_gain;
        logic                neg;
        logic                sat;
        bin_result_t         res;
        twice_sum = '0;
        for (int n = 0; n <= GRID; n++)
        begin
            term = longint'(corr_store[n]) * longint'(cos_table[(int'(k) * n) % GRID]);
            if (n != 0 && n != GRID)
                term = term * 2;
            twice_sum = twice_sum + term;
        end
        neg    = twice_sum[127];
        mag    = neg ? -twice_sum : twice_sum;
        k_gain = 64'(k) * 64'(k) * 64'(gain_now);
        scaled = (mag * 128'(k_gain)) >> (int'(shift_now) + SHIFT_BIAS);
        sat    = neg ? (scaled > ABS_LIM) : (scaled > ABS_LIM - 1);
        if (sat)
            scaled = neg ? ABS_LIM : ABS_LIM - 1;
        res.bin_out    = k;
        res.absorbance = scaled[ABS_W-1:0];
        if (neg)
            res.absorbance = -res.absorbance;
        res.saturated  = sat;
        return res;
    endfunction

    // Random transaction. Loads dominate; a tenth of them aim past the grid and
    // must be dropped. Bins cover the grid, the wrapped range and the corners.
    function automatic spec_item_t random_item();
        spec_item_t it;
        it.cmd = ($urandom_range(0, 99) < 30) ? CMD_BIN : CMD_LOAD;
        if ($urandom_range(0, 9) == 0)
            it.sample_index = BIN_W'($urandom_range(GRID + 1, int'(BIN_MAX)));
        else
            it.sample_index = BIN_W'($urandom_range(0, GRID));
        case ($urandom_range(0, 15))
            0:       it.sample_value = SAMPLE_MIN;
            1:       it.sample_value = SAMPLE_MAX;
            2:       it.sample_value = '0;
            3:       it.sample_value = '1;
            default: it.sample_value = SAMPLE_IN_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: it.bin_index = BIN_W'($urandom_range(0, GRID));
            5, 6, 7, 8:    it.bin_index = BIN_W'($urandom);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       it.bin_index = '0;
                    1:       it.bin_index = BIN_W'(GRID);
                    2:       it.bin_index = BIN_MAX;
                    default: it.bin_index = BIN_W'(GRID / 2);
                endcase
            end
        endcase
        return it;
    endfunction

    // Waits until every transaction is accepted and every bin has come out,
    // then lets a full bin time pass so that no trailing load is in flight.
    task automatic drain();
        do
            @(negedge clk);
        while (cmd_queue.size() != 0 || s_tvalid || bins_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_GAIN)
            gain_now = data[GAIN_W-1:0];
        else
            shift_now = data[SHIFT_W-1:0];
    endtask

    // One configuration phase. The shift is written with junk above its six
    // bits, which the block has to ignore.
    task automatic run_phase(input logic [GAIN_W-1:0] g, input logic [SHIFT_W-1:0] sh,
                             input int count, input bit with_hold);
        spec_item_t it;
        drain();
        write_reg(REG_GAIN, g);
        write_reg(REG_OUT_SHIFT, CFG_DATA_W'({10'($urandom), sh}));
        @(negedge clk);
        if (with_hold)
        begin
            // Back-to-back bins so that the output register and the sweep
            // both fill up while the receiver is holding off.
            hold_req <= 1'b1;
            repeat (3)
            begin
                it     = random_item();
                it.cmd = CMD_BIN;
                cmd_queue.push_back(it);
            end
        end
        repeat (count) cmd_queue.push_back(random_item());
    endtask

    // Driver: offers the queued transactions on the slave side. The predictor
    // is updated at the edge where a transaction is accepted, so loads land
    // in the store in the same order the block sees them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (cur_item.cmd == CMD_LOAD)
                begin
                    // Loads beyond the last grid point are dropped by the block.
                    if (cur_item.sample_index <= BIN_W'(GRID))
                        corr_store[cur_item.sample_index] = cur_item.sample_value;
                end
                else
                begin
                    bins_due.push_back(predict_bin(cur_item.bin_index));
                end
                if (tx_calm > 0)
                begin
                    tx_calm = tx_calm - 1;
                    tx_gap  = 0;
                end
                else
                begin
                    if ($urandom_range(0, 39) == 0)
                        tx_calm = $urandom_range(16, 64);
                    tx_gap = gap_len();
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap = tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_queue.size() > 0)
                begin
                    cur_item = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, cur_item.bin_index, cur_item.sample_value,
                                 cur_item.sample_index};
                    s_tuser  <= cur_item.cmd;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction against the oldest predicted
    // bin and drives m_tready with random gaps, calm stretches and the one
    // long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen_bin.bin_out    = m_tdata[BIN_W-1:0];
                seen_bin.absorbance = m_tdata[BIN_W+ABS_W-1:BIN_W];
                seen_bin.saturated  = m_tuser[0];
                if (bins_due.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: bin %0d absorbance %0d saturated %0b",
                                 seen_bin.bin_out, $signed(seen_bin.absorbance),
                                 seen_bin.saturated);
                end
                else
                begin
                    want_bin = bins_due.pop_front();
                    if (seen_bin.bin_out !== want_bin.bin_out
                        || seen_bin.absorbance !== want_bin.absorbance
                        || seen_bin.saturated !== want_bin.saturated)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected bin %0d abs %0d sat %0b, got bin %0d abs %0d sat %0b",
                                     want_bin.bin_out, $signed(want_bin.absorbance),
                                     want_bin.saturated, seen_bin.bin_out,
                                     $signed(seen_bin.absorbance), seen_bin.saturated);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap = rx_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                if (rx_calm > 0)
                    rx_calm = rx_calm - 1;
                else if ($urandom_range(0, 199) == 0)
                    rx_calm = $urandom_range(100, 2000);
                else if ($urandom_range(0, 7) == 0)
                    rx_gap = gap_len();
                m_tready <= (rx_gap == 0);
            end
        end
    end

    // Watchdog: a correct run never goes this long without a transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        longint unsigned q4;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned h;
        longint unsigned sub;
        longint unsigned v;
        logic [SAMPLE_IN_W-1:0] val;

        // Cosine ROM, built by quarter-wave symmetry from a Q30 Taylor series
        // evaluated Horner style; the divisors are (2j)(2j-1) for j = 7 down to 1.
        for (int p = 0; p < GRID; p++)
        begin
            q4   = 4 * p;
            quad = q4 / GRID;
            r    = q4 % GRID;
            if (quad[0])
                r = GRID - r;
            t  = (r * HALF_PI_Q30) / GRID;
            t2 = (t * t) >> 30;
            h  = Q30_ONE;
            for (int i = 0; i < 7; i++)
            begin
                sub = ((t2 * h) >> 30) / ((14 - 2 * i) * (13 - 2 * i));
                h   = (sub > Q30_ONE) ? 0 : Q30_ONE - sub;
            end
            v = (h + (64'd1 << (COS_SHIFT - 1))) >> COS_SHIFT;
            if (v > COS_MAX)
                v = COS_MAX;
            cos_table[p] = (quad == 1 || quad == 2) ? -int'(v) : int'(v);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The store is undefined after reset, so every grid point is loaded
        // before the first bin is asked for.
        for (int n = 0; n <= GRID; n++)
        begin
            val = SAMPLE_IN_W'($urandom);
            if ($urandom_range(0, 7) == 0)
                val = n[0] ? SAMPLE_MAX : SAMPLE_MIN;
            cmd_queue.push_back('{CMD_LOAD, BIN_W'(n), val, BIN_W'($urandom)});
        end

        // Directed part under the reset configuration: extreme samples at
        // both ends of the grid, loads past the grid that must be dropped,
        // and bins at zero, inside the grid, at the grid size and wrapped.
        cmd_queue.push_back('{CMD_LOAD, 11'd0, SAMPLE_MIN, 11'd0});
        cmd_queue.push_back('{CMD_LOAD, BIN_W'(GRID), SAMPLE_MAX, 11'd0});
        cmd_queue.push_back('{CMD_LOAD, BIN_W'(GRID + 1), SAMPLE_MAX, 11'd0});
        cmd_queue.push_back('{CMD_LOAD, BIN_MAX, SAMPLE_MIN, BIN_MAX});
        cmd_queue.push_back('{CMD_LOAD, BIN_W'(GRID / 2), 24'd0, 11'd0});
        cmd_queue.push_back('{CMD_LOAD, 11'd1, '1, 11'd0});
        cmd_queue.push_back('{CMD_BIN, 11'd0, 24'd0, 11'd0});
        cmd_queue.push_back('{CMD_BIN, 11'd0, 24'd0, 11'd1});
        cmd_queue.push_back('{CMD_BIN, BIN_MAX, '1, 11'd2});
        cmd_queue.push_back('{CMD_BIN, 11'd0, 24'd0, 11'd255});
        cmd_queue.push_back('{CMD_BIN, 11'd0, 24'd0, BIN_W'(GRID / 2)});
        cmd_queue.push_back('{CMD_BIN, 11'd0, 24'd0, BIN_W'(GRID - 1)});
        cmd_queue.push_back('{CMD_BIN, 11'd0, 24'd0, BIN_W'(GRID)});
        cmd_queue.push_back('{CMD_BIN, 11'd0, 24'd0, BIN_W'(GRID + 1)});
        cmd_queue.push_back('{CMD_BIN, 11'd0, 24'd0, BIN_W'(GRID + GRID / 2)});
        cmd_queue.push_back('{CMD_BIN, 11'd0, 24'd0, BIN_MAX});
        cmd_queue.push_back('{CMD_LOAD, BIN_W'(GRID), SAMPLE_MIN, 11'd0});
        cmd_queue.push_back('{CMD_BIN, 11'd0, 24'd0, BIN_W'(GRID)});
        repeat (100) cmd_queue.push_back(random_item());

        // Configuration sweep: maximum gain with no extra shift drives most
        // bins into saturation, zero gain with the largest shift gives zeros,
        // then the smallest gain, a random mix with the long receiver hold-off,
        // maximum gain with maximum shift, and a final random setting.
        run_phase('1, 6'd0, 100, 1'b0);
        run_phase('0, 6'd63, 70, 1'b0);
        run_phase(32'd1, 6'd0, 70, 1'b0);
        run_phase(GAIN_W'($urandom), SHIFT_W'($urandom_range(8, 24)), 90, 1'b1);
        run_phase('1, 6'd63, 70, 1'b0);
        run_phase(GAIN_W'($urandom), SHIFT_W'($urandom_range(0, 63)), 80, 1'b0);

        drain();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
sv/tcs_pkg.sv
sv/tcs_ram.sv
sv/tcs_cos_rom.sv
sv/tcs_datapath.sv
sv/tcs_ctrl.sv
sv/trapezoid_cosine_spectrum.sv
test/tb_trapezoid_cosine_spectrum.sv
